### rtl/fgn_pkg.sv
// Shared types and constants for the fractal gradient noise unit.
// No dependencies; every other file in rtl/ depends on this package.
package fgn_pkg;

  localparam int TABLE_SIZE   = 256;
  localparam int TAB_AW       = $clog2(TABLE_SIZE);
  localparam int OCTAVE_LIMIT = 8;
  localparam int FRAC_BITS    = 16;

  localparam int CRD_W  = 24;
  localparam int CRD_FB = 16;
  localparam int FREQ_W = 32;
  localparam int AMP_W  = FRAC_BITS + 1;
  localparam int U_W    = FRAC_BITS + 1;
  localparam int VAL_W  = FRAC_BITS + 5;
  localparam int SUM_W  = FRAC_BITS + 10;
  localparam int ASUM_W = FRAC_BITS + 5;
  localparam int QB     = FRAC_BITS + 4;
  localparam int NQ_W   = QB + 2;
  localparam int MA_W   = 34;
  localparam int MB_W   = 26;
  localparam int P_W    = MA_W + MB_W;
  localparam int RES_W  = 32;
  localparam int NSLOT  = 6;
  localparam int NQUEUE = 8;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_AW-1:0] CFG_DIMS    = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_FADE    = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_OCTAVES = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_PERSIST = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_LACUN   = 3'd4;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_COORD,
    OP_FADE_SQ,
    OP_FADE_MUL,
    OP_FADE_LIN,
    OP_LOOK,
    OP_CAP,
    OP_LERP,
    OP_ACC,
    OP_AMP,
    OP_FREQ,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MAP,
    OP_FIN
  } fgn_op_t;

  typedef struct packed {
    logic       use_base;
    logic [2:0] base_slot;
    logic [1:0] dim;
    logic       inc;
    logic       store;
    logic [2:0] slot;
    logic       push;
    logic [2:0] corner;
  } fgn_look_t;

  typedef struct packed {
    fgn_op_t    op;
    logic [1:0] dims;
    logic [1:0] dim;
    fgn_look_t  look;
  } fgn_cmd_t;

endpackage

### rtl/fgn_if.sv
// Valid/ready channel interfaces for the sample/load input and the noise result.
// Depends on fgn_pkg for field widths.
interface fgn_in_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic [fgn_pkg::TAB_AW-1:0]        table_index;
  logic [7:0]                        table_value;
  logic [fgn_pkg::CRD_W-1:0]         coord_x;
  logic [fgn_pkg::CRD_W-1:0]         coord_y;
  logic [fgn_pkg::CRD_W-1:0]         coord_z;
  logic signed [fgn_pkg::RES_W-1:0]  out_min;
  logic signed [fgn_pkg::RES_W-1:0]  out_max;

  modport source (output valid, func, table_index, table_value, coord_x, coord_y, coord_z,
                  out_min, out_max, input ready);
  modport sink (input valid, func, table_index, table_value, coord_x, coord_y, coord_z,
                out_min, out_max, output ready);
endinterface

interface fgn_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [fgn_pkg::RES_W-1:0]  noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface

### rtl/fgn_datapath.sv
// Datapath: permutation memory, shared multiplier, octave accumulators and divider.
// Driven one operation per cycle by fgn_ctrl; depends on fgn_pkg.
module fgn_datapath (
  input  logic                              clk,
  input  fgn_pkg::fgn_cmd_t                 cmd,
  input  logic [fgn_pkg::TAB_AW-1:0]        table_index,
  input  logic [7:0]                        table_value,
  input  logic [fgn_pkg::CRD_W-1:0]         coord_x,
  input  logic [fgn_pkg::CRD_W-1:0]         coord_y,
  input  logic [fgn_pkg::CRD_W-1:0]         coord_z,
  input  logic signed [fgn_pkg::RES_W-1:0]  out_min,
  input  logic signed [fgn_pkg::RES_W-1:0]  out_max,
  input  logic [15:0]                       persistence,
  input  logic [15:0]                       lacunarity,
  output logic signed [fgn_pkg::RES_W-1:0]  noise_value
);
  import fgn_pkg::*;

  localparam logic [FREQ_W-1:0]        FREQ_ONE  = FREQ_W'(1 << 16);
  localparam logic [AMP_W-1:0]         AMP_ONE   = AMP_W'(1 << FRAC_BITS);
  localparam logic [FRAC_BITS+1:0]     THREE_ONE = (FRAC_BITS + 2)'(3 << FRAC_BITS);
  localparam logic signed [VAL_W-1:0]  ONE_V     = VAL_W'(1 << FRAC_BITS);
  localparam logic signed [NQ_W-1:0]   ONE_N     = NQ_W'(1 << FRAC_BITS);
  localparam int                       SCL_W     = 40;
  localparam int                       FIN_W     = 41;
  localparam logic signed [FIN_W-1:0]  RES_MAX   = 41'sd2147483647;
  localparam logic signed [FIN_W-1:0]  RES_MIN   = -41'sd2147483648;

  logic [7:0]               perm_mem [TABLE_SIZE];
  logic [7:0]               mem_q_r;

  logic [CRD_W-1:0]         crd_r [3];
  logic signed [RES_W-1:0]  lo_r, hi_r;
  logic [FREQ_W-1:0]        freq_r;
  logic [AMP_W-1:0]         amp_r;
  logic [ASUM_W-1:0]        asum_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [7:0]               cell_r [3];
  logic [FRAC_BITS-1:0]     frac_r [3];
  logic [U_W-1:0]           u_r [3];
  logic [FRAC_BITS-1:0]     t2_r;
  logic [7:0]               hs_r [NSLOT];
  logic signed [VAL_W-1:0]  q_r [NQUEUE];
  logic [3:0]               qcnt_r;
  logic [ASUM_W:0]          rem_r;
  logic [QB-1:0]            dvd_r;
  logic                     neg_r;
  logic signed [SCL_W-1:0]  scl_r;
  logic signed [RES_W-1:0]  res_r;

  logic signed [MA_W-1:0]   ma;
  logic signed [MB_W-1:0]   mb;
  logic signed [P_W-1:0]    prod;
  logic [FRAC_BITS-1:0]     t;
  logic [FRAC_BITS+1:0]     fade3;
  logic signed [VAL_W:0]    dif;
  logic signed [VAL_W-1:0]  lerp_d, lerp_res;
  logic [3:0]               qm2;
  logic [CRD_W-1:0]         scaled;
  logic [7:0]               base, rd_addr;
  logic signed [VAL_W-1:0]  x0, y0, z0, gx, gy, gz, tx, ty, tz, grad;
  logic signed [SUM_W-1:0]  acc_term;
  logic [35:0]              fq;
  logic [FREQ_W-1:0]        freq_sat;
  logic [SUM_W-1:0]         mag;
  logic [SUM_W+FRAC_BITS-1:0] dvd_full;
  logic [ASUM_W:0]          rem_sh;
  logic                     ge;
  logic signed [NQ_W-1:0]   qv, nval, nplus;
  logic signed [RES_W:0]    span;
  logic signed [FIN_W-1:0]  fin;
  logic signed [RES_W-1:0]  fin_sat;

  assign t      = frac_r[cmd.dim];
  assign fade3  = THREE_ONE - {1'b0, t, 1'b0};
  assign dif    = (VAL_W + 1)'(q_r[1]) - (VAL_W + 1)'(q_r[0]);
  assign qv     = $signed({2'b00, dvd_r});
  assign nval   = neg_r ? -qv : qv;
  assign nplus  = nval + ONE_N;
  assign span   = (RES_W + 1)'(hi_r) - (RES_W + 1)'(lo_r);

  // One shared multiplier; operands are picked by the current operation.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_COORD: begin
        ma = MA_W'(freq_r);
        mb = MB_W'(crd_r[cmd.dim]);
      end
      OP_FADE_SQ: begin
        ma = MA_W'(t);
        mb = MB_W'(t);
      end
      OP_FADE_MUL: begin
        ma = MA_W'(t2_r);
        mb = MB_W'(fade3);
      end
      OP_LERP: begin
        ma = MA_W'(dif);
        mb = MB_W'(u_r[cmd.dim]);
      end
      OP_ACC: begin
        ma = MA_W'(q_r[0]);
        mb = MB_W'(amp_r);
      end
      OP_AMP: begin
        ma = MA_W'(amp_r);
        mb = MB_W'(persistence);
      end
      OP_FREQ: begin
        ma = MA_W'(freq_r);
        mb = MB_W'(lacunarity);
      end
      OP_MAP: begin
        ma = MA_W'(span);
        mb = MB_W'(nplus);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod     = ma * mb;
  assign scaled   = prod[16+CRD_W-1:16];
  assign lerp_d   = $signed(prod[FRAC_BITS+VAL_W-1:FRAC_BITS]);
  assign lerp_res = q_r[0] + lerp_d;
  assign qm2      = qcnt_r - 4'd2;
  assign acc_term = $signed(prod[FRAC_BITS+SUM_W-1:FRAC_BITS]);
  assign fq       = prod[47:12];
  assign freq_sat = (|fq[35:32]) ? '1 : fq[FREQ_W-1:0];

  // Table address: optional parent hash plus lattice cell, wrapping at 256.
  assign base    = cmd.look.use_base ? hs_r[cmd.look.base_slot] : 8'd0;
  assign rd_addr = base + cell_r[cmd.look.dim] + {7'd0, cmd.look.inc};

  // Sign-sum gradient for the corner being captured.
  assign x0 = $signed(VAL_W'(frac_r[0]));
  assign y0 = $signed(VAL_W'(frac_r[1]));
  assign z0 = $signed(VAL_W'(frac_r[2]));
  assign gx = cmd.look.corner[0] ? x0 - ONE_V : x0;
  assign gy = cmd.look.corner[1] ? y0 - ONE_V : y0;
  assign gz = cmd.look.corner[2] ? z0 - ONE_V : z0;
  assign tx = mem_q_r[0] ? gx : -gx;
  assign ty = (cmd.dims >= 2'd2) ? (mem_q_r[1] ? gy : -gy) : '0;
  assign tz = (cmd.dims == 2'd3) ? (mem_q_r[2] ? gz : -gz) : '0;
  assign grad = tx + ty + tz;

  assign mag      = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign dvd_full = {mag, {FRAC_BITS{1'b0}}};
  assign rem_sh   = {rem_r[ASUM_W-1:0], dvd_r[QB-1]};
  assign ge       = rem_sh >= {1'b0, asum_r};

  assign fin     = FIN_W'(lo_r) + FIN_W'(scl_r);
  assign fin_sat = (fin > RES_MAX) ? RES_W'(RES_MAX) :
                   (fin < RES_MIN) ? RES_W'(RES_MIN) : RES_W'(fin);

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      perm_mem[table_index] <= table_value;
    end
    if (cmd.op == OP_LOOK) begin
      mem_q_r <= perm_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_START: begin
        crd_r[0] <= coord_x;
        crd_r[1] <= coord_y;
        crd_r[2] <= coord_z;
        lo_r     <= out_min;
        hi_r     <= out_max;
        freq_r   <= FREQ_ONE;
        amp_r    <= AMP_ONE;
        asum_r   <= '0;
        sum_r    <= '0;
        qcnt_r   <= '0;
      end
      OP_COORD: begin
        cell_r[cmd.dim] <= scaled[CRD_W-1:CRD_FB];
        frac_r[cmd.dim] <= scaled[CRD_FB-1:0];
      end
      OP_FADE_SQ:  t2_r <= prod[2*FRAC_BITS-1:FRAC_BITS];
      OP_FADE_MUL: u_r[cmd.dim] <= prod[2*FRAC_BITS:FRAC_BITS];
      OP_FADE_LIN: u_r[cmd.dim] <= U_W'(t);
      OP_CAP: begin
        if (cmd.look.store) begin
          hs_r[cmd.look.slot] <= mem_q_r;
        end
        if (cmd.look.push) begin
          q_r[qcnt_r[2:0]] <= grad;
          qcnt_r           <= qcnt_r + 4'd1;
        end
      end
      OP_LERP: begin
        // pop the two head entries, append the blend at the tail
        for (int i = 0; i < NQUEUE - 2; i++) begin
          if (3'(i) != qm2[2:0]) begin
            q_r[i] <= q_r[i+2];
          end
        end
        q_r[qm2[2:0]] <= lerp_res;
        qcnt_r        <= qcnt_r - 4'd1;
      end
      OP_ACC: begin
        sum_r  <= sum_r + acc_term;
        asum_r <= asum_r + ASUM_W'(amp_r);
        qcnt_r <= '0;
      end
      OP_AMP:  amp_r  <= prod[16+AMP_W-1:16];
      OP_FREQ: freq_r <= freq_sat;
      OP_DIV_INIT: begin
        rem_r <= (ASUM_W + 1)'(dvd_full >> QB);
        dvd_r <= dvd_full[QB-1:0];
        neg_r <= sum_r[SUM_W-1];
      end
      OP_DIV_STEP: begin
        rem_r <= ge ? rem_sh - {1'b0, asum_r} : rem_sh;
        dvd_r <= {dvd_r[QB-2:0], ge};
      end
      OP_MAP: scl_r <= $signed(prod[17+SCL_W-1:17]);
      OP_FIN: res_r <= fin_sat;
      default: begin
      end
    endcase
  end

  assign noise_value = res_r;

endmodule

### rtl/fgn_ctrl.sv
// Controller: sequences octaves, table lookups, blends and the divider.
// Issues one fgn_cmd_t per cycle to fgn_datapath; depends on fgn_pkg.
module fgn_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_func,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  input  logic [1:0]         dims_cfg,
  input  logic               smooth_cfg,
  input  logic [3:0]         octs_cfg,
  output fgn_pkg::fgn_cmd_t  cmd
);
  import fgn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COORD,
    S_FADE_A,
    S_FADE_B,
    S_LOOK,
    S_CAP,
    S_LERP,
    S_ACC,
    S_AMP,
    S_FREQ,
    S_DIVI,
    S_DIV,
    S_MAP,
    S_FIN
  } state_t;

  state_t      state_r;
  logic [1:0]  dim_r;
  logic [4:0]  cnt_r;
  logic [3:0]  oct_r;
  logic        out_valid_r;

  logic [1:0]  eff_dims;
  logic [3:0]  eff_octs;
  logic [3:0]  nlook;
  logic [2:0]  nlerp;
  logic        fin_go;

  function automatic fgn_look_t look_of(input logic [3:0] j, input logic [1:0] d);
    fgn_look_t  lk;
    logic [3:0] k;
    lk = '0;
    if (j < 4'd2) begin
      lk.dim    = 2'd0;
      lk.inc    = j[0];
      lk.store  = 1'b1;
      lk.slot   = 3'(j);
      lk.push   = (d == 2'd1);
      lk.corner = 3'(j);
    end else if (j < 4'd6) begin
      k            = j - 4'd2;
      lk.use_base  = 1'b1;
      lk.base_slot = {2'b00, k[0]};
      lk.dim       = 2'd1;
      lk.inc       = k[1];
      lk.store     = 1'b1;
      lk.slot      = 3'(k) + 3'd2;
      lk.push      = (d == 2'd2);
      lk.corner    = k[2:0];
    end else begin
      k            = j - 4'd6;
      lk.use_base  = 1'b1;
      lk.base_slot = {1'b0, k[1:0]} + 3'd2;
      lk.dim       = 2'd2;
      lk.inc       = k[2];
      lk.push      = 1'b1;
      lk.corner    = k[2:0];
    end
    return lk;
  endfunction

  // which fade factor blends level m of the reduction
  function automatic logic [1:0] lerp_dim(input logic [2:0] m, input logic [1:0] d);
    logic [1:0] r;
    r = 2'd0;
    if (d == 2'd3) begin
      r = (m < 3'd4) ? 2'd0 : (m < 3'd6) ? 2'd1 : 2'd2;
    end else if (d == 2'd2) begin
      r = (m < 3'd2) ? 2'd0 : 2'd1;
    end
    return r;
  endfunction

  assign eff_dims = (dims_cfg == 2'd0) ? 2'd1 : dims_cfg;

  always_comb begin
    if (octs_cfg == 4'd0) begin
      eff_octs = 4'd1;
    end else if ({1'b0, octs_cfg} > 5'(OCTAVE_LIMIT)) begin
      eff_octs = 4'(OCTAVE_LIMIT);
    end else begin
      eff_octs = octs_cfg;
    end
  end

  always_comb begin
    unique case (eff_dims)
      2'd3: begin
        nlook = 4'd14;
        nlerp = 3'd7;
      end
      2'd2: begin
        nlook = 4'd6;
        nlerp = 3'd3;
      end
      default: begin
        nlook = 4'd2;
        nlerp = 3'd1;
      end
    endcase
  end

  assign fin_go    = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd      = '0;
    cmd.op   = OP_NONE;
    cmd.dims = eff_dims;
    cmd.dim  = dim_r;
    cmd.look = look_of(cnt_r[3:0], eff_dims);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = (in_func == FUNC_LOAD) ? OP_LOAD : OP_START;
        end
      end
      S_COORD:  cmd.op = OP_COORD;
      S_FADE_A: cmd.op = smooth_cfg ? OP_FADE_SQ : OP_FADE_LIN;
      S_FADE_B: cmd.op = OP_FADE_MUL;
      S_LOOK:   cmd.op = OP_LOOK;
      S_CAP:    cmd.op = OP_CAP;
      S_LERP: begin
        cmd.op  = OP_LERP;
        cmd.dim = lerp_dim(cnt_r[2:0], eff_dims);
      end
      S_ACC:    cmd.op = OP_ACC;
      S_AMP:    cmd.op = OP_AMP;
      S_FREQ:   cmd.op = OP_FREQ;
      S_DIVI:   cmd.op = OP_DIV_INIT;
      S_DIV:    cmd.op = OP_DIV_STEP;
      S_MAP:    cmd.op = OP_MAP;
      S_FIN:    cmd.op = fin_go ? OP_FIN : OP_NONE;
      default:  cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dim_r       <= '0;
      cnt_r       <= '0;
      oct_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (state_r == S_FIN && fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_func == FUNC_SAMPLE) begin
            dim_r   <= '0;
            oct_r   <= '0;
            state_r <= S_COORD;
          end
        end
        S_COORD: state_r <= S_FADE_A;
        S_FADE_A, S_FADE_B: begin
          if (state_r == S_FADE_A && smooth_cfg) begin
            state_r <= S_FADE_B;
          end else if (dim_r == eff_dims - 2'd1) begin
            cnt_r   <= '0;
            state_r <= S_LOOK;
          end else begin
            dim_r   <= dim_r + 2'd1;
            state_r <= S_COORD;
          end
        end
        S_LOOK: state_r <= S_CAP;
        S_CAP: begin
          if (cnt_r[3:0] == nlook - 4'd1) begin
            cnt_r   <= '0;
            state_r <= S_LERP;
          end else begin
            cnt_r   <= cnt_r + 5'd1;
            state_r <= S_LOOK;
          end
        end
        S_LERP: begin
          if (cnt_r[2:0] == nlerp - 3'd1) begin
            state_r <= S_ACC;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_ACC: state_r <= S_AMP;
        S_AMP: state_r <= S_FREQ;
        S_FREQ: begin
          if (oct_r == eff_octs - 4'd1) begin
            state_r <= S_DIVI;
          end else begin
            oct_r   <= oct_r + 4'd1;
            dim_r   <= '0;
            state_r <= S_COORD;
          end
        end
        S_DIVI: begin
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (cnt_r == 5'(QB - 1)) begin
            state_r <= S_MAP;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_MAP: state_r <= S_FIN;
        S_FIN: begin
          // hold the result until the output register is free
          if (fin_go) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/fractal_gradient_noise_unit.sv
// Fractal gradient noise unit. Per octave a sample scales and fades each of its D
// dimensions (smoothstep or linear fade), then does L = 2/6/14 table lookups and M = 1/3/7
// blends for D = 1/2/3; all lookups use the single-port table read and all multiplies
// the one shared multiplier.
// One sample at a time; the next transaction is taken while a result waits.
// Synchronous active-low reset restores the config defaults; table contents are not reset.
module fractal_gradient_noise_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  fgn_in_if.sink                        in_bus,
  fgn_out_if.source                     out_bus,
  input  logic                          cfg_we,
  input  logic [fgn_pkg::CFG_AW-1:0]    cfg_index,
  input  logic [fgn_pkg::CFG_DW-1:0]    cfg_wdata
);
  import fgn_pkg::*;

  logic [1:0]  dims_r;
  logic        smooth_r;
  logic [3:0]  octs_r;
  logic [15:0] pers_r;
  logic [15:0] lac_r;
  fgn_cmd_t    cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r   <= 2'd3;
      smooth_r <= 1'b1;
      octs_r   <= 4'd1;
      pers_r   <= 16'd32768;
      lac_r    <= 16'd8192;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIMS:    dims_r   <= cfg_wdata[1:0];
        CFG_FADE:    smooth_r <= cfg_wdata[0];
        CFG_OCTAVES: octs_r   <= cfg_wdata[3:0];
        CFG_PERSIST: pers_r   <= cfg_wdata;
        CFG_LACUN:   lac_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  fgn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_func    (in_bus.func),
    .in_ready   (in_bus.ready),
    .out_ready  (out_bus.ready),
    .out_valid  (out_bus.valid),
    .dims_cfg   (dims_r),
    .smooth_cfg (smooth_r),
    .octs_cfg   (octs_r),
    .cmd        (cmd)
  );

  fgn_datapath u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .table_index (in_bus.table_index),
    .table_value (in_bus.table_value),
    .coord_x     (in_bus.coord_x),
    .coord_y     (in_bus.coord_y),
    .coord_z     (in_bus.coord_z),
    .out_min     (in_bus.out_min),
    .out_max     (in_bus.out_max),
    .persistence (pers_r),
    .lacunarity  (lac_r),
    .noise_value (out_bus.noise_value)
  );

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for fractal_gradient_noise_unit: loads the permutation table,
// sweeps the config registers and checks every noise result against a built-in predictor.
// Depends on rtl/fgn_pkg.sv, rtl/fgn_if.sv and rtl/fractal_gradient_noise_unit.sv.
module tb;
  import fgn_pkg::*;

  localparam longint ONE_Q     = longint'(1) << FRAC_BITS;
  localparam int     SETTLE    = 8;
  localparam int     MAX_SHOWN = 10;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_AW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  fgn_in_if  in_bus ();
  fgn_out_if out_bus ();

  fractal_gradient_noise_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus.sink),
    .out_bus   (out_bus.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [7:0]  perm [TABLE_SIZE];
  logic [1:0]  dims_reg   = 2'd3;
  logic        smooth_reg = 1'b1;
  logic [3:0]  oct_reg    = 4'd1;
  logic [15:0] persist_reg = 16'd32768;
  logic [15:0] lacun_reg   = 16'd8192;

  logic signed [RES_W-1:0] noise_expected [$];
  int  n_errors;
  bit  steady;
  int  out_stall;

  always #1 clk = ~clk;

  function automatic longint fade(longint t);
    longint t2;
    if (!smooth_reg) return t;
    t2 = (t * t) >>> FRAC_BITS;
    return (t2 * (3 * ONE_Q - 2 * t)) >>> FRAC_BITS;
  endfunction

  function automatic longint lerp(longint a, longint b, longint u);
    return a + (((b - a) * u) >>> FRAC_BITS);
  endfunction

  function automatic longint grad(int h, longint x, longint y, longint z, int d);
    longint r;
    r = h[0] ? x : -x;
    if (d >= 2) r += h[1] ? y : -y;
    if (d >= 3) r += h[2] ? z : -z;
    return r;
  endfunction

  function automatic int pt(int i);
    return int'(perm[i & (TABLE_SIZE - 1)]);
  endfunction

  function automatic longint lattice_noise(int c0, int c1, int c2,
                                           longint x0, longint y0, longint z0, int d);
    longint u, v, w, x1, y1, z1, lo, hi;
    int a, b, aa, ab, ba, bb;
    u = fade(x0); v = fade(y0); w = fade(z0);
    x1 = x0 - ONE_Q; y1 = y0 - ONE_Q; z1 = z0 - ONE_Q;
    a = pt(c0); b = pt(c0 + 1);
    if (d == 1) return lerp(grad(a, x0, 0, 0, 1), grad(b, x1, 0, 0, 1), u);
    aa = pt(a + c1); ab = pt(a + c1 + 1);
    ba = pt(b + c1); bb = pt(b + c1 + 1);
    if (d == 2)
      return lerp(lerp(grad(aa, x0, y0, 0, 2), grad(ba, x1, y0, 0, 2), u),
                  lerp(grad(ab, x0, y1, 0, 2), grad(bb, x1, y1, 0, 2), u), v);
    lo = lerp(lerp(grad(pt(aa + c2), x0, y0, z0, 3), grad(pt(ba + c2), x1, y0, z0, 3), u),
              lerp(grad(pt(ab + c2), x0, y1, z0, 3), grad(pt(bb + c2), x1, y1, z0, 3), u), v);
    hi = lerp(lerp(grad(pt(aa + c2 + 1), x0, y0, z1, 3), grad(pt(ba + c2 + 1), x1, y0, z1, 3), u),
              lerp(grad(pt(ab + c2 + 1), x0, y1, z1, 3), grad(pt(bb + c2 + 1), x1, y1, z1, 3), u),
              v);
    return lerp(lo, hi, w);
  endfunction

  function automatic logic signed [RES_W-1:0] fbm_noise(
      logic [CRD_W-1:0] cx, logic [CRD_W-1:0] cy, logic [CRD_W-1:0] cz,
      logic signed [RES_W-1:0] lo_q, logic signed [RES_W-1:0] hi_q);
    longint crd [3];
    int     c [3];
    longint f [3];
    longint freq, amp, ampsum, sum, n, res, s;
    int     d, octs;
    crd[0] = longint'(cx); crd[1] = longint'(cy); crd[2] = longint'(cz);
    d = (dims_reg == 0) ? 1 : int'(dims_reg);
    octs = (oct_reg == 0) ? 1 : int'(oct_reg);
    if (octs > OCTAVE_LIMIT) octs = OCTAVE_LIMIT;
    freq = 64'h10000; amp = ONE_Q; ampsum = 0; sum = 0;
    for (int i = 0; i < octs; i++) begin
      for (int k = 0; k < 3; k++) begin
        s = ((crd[k] * freq) >> 16) & 64'hFF_FFFF;
        c[k] = int'(s >> 16);
        f[k] = ((s & 64'hFFFF) << 8) >> (24 - FRAC_BITS);
      end
      if (d < 3) begin c[2] = 0; f[2] = 0; end
      if (d < 2) begin c[1] = 0; f[1] = 0; end
      sum += (lattice_noise(c[0], c[1], c[2], f[0], f[1], f[2], d) * amp) >>> FRAC_BITS;
      ampsum += amp;
      amp = (amp * longint'(persist_reg)) >> 16;
      freq = (freq * longint'(lacun_reg)) >> 12;
      if (freq > 64'hFFFF_FFFF) freq = 64'hFFFF_FFFF;
    end
    n = (sum * ONE_Q) / ampsum;
    res = longint'(lo_q) + (((longint'(hi_q) - longint'(lo_q)) * (n + ONE_Q)) >>> (FRAC_BITS + 1));
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res[RES_W-1:0];
  endfunction

  // result checker and sink-side stalls
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (noise_expected.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_SHOWN)
          $display("unexpected result noise_value=%0d", out_bus.noise_value);
      end else begin
        if (out_bus.noise_value !== noise_expected[0]) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN)
            $display("noise_value mismatch: expected %0d actual %0d",
                     noise_expected[0], out_bus.noise_value);
        end
        void'(noise_expected.pop_front());
      end
    end
    if (out_stall > 0) begin
      out_stall--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0)
        out_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    end
  end

  function automatic int gap_len();
    if (steady) return 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 0;
      9:             return $urandom_range(10, 40);
      default:       return $urandom_range(1, 3);
    endcase
  endfunction

  // called at a rising edge; returns at the edge where the transaction is accepted
  // (or after the following gap)
  task automatic send_item(logic func, logic [7:0] idx, logic [7:0] val,
                           logic [CRD_W-1:0] x, logic [CRD_W-1:0] y, logic [CRD_W-1:0] z,
                           logic signed [RES_W-1:0] lo_q, logic signed [RES_W-1:0] hi_q);
    int gap;
    in_bus.valid       <= 1'b1;
    in_bus.func        <= func;
    in_bus.table_index <= idx;
    in_bus.table_value <= val;
    in_bus.coord_x     <= x;
    in_bus.coord_y     <= y;
    in_bus.coord_z     <= z;
    in_bus.out_min     <= lo_q;
    in_bus.out_max     <= hi_q;
    @(negedge clk);
    while (!in_bus.ready) @(negedge clk);
    @(posedge clk);
    if (func == FUNC_LOAD) perm[idx] = val;
    else noise_expected.push_back(fbm_noise(x, y, z, lo_q, hi_q));
    gap = gap_len();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic sample(logic [CRD_W-1:0] x, logic [CRD_W-1:0] y, logic [CRD_W-1:0] z,
                        logic signed [RES_W-1:0] lo_q, logic signed [RES_W-1:0] hi_q);
    send_item(FUNC_SAMPLE, 8'($urandom), 8'($urandom), x, y, z, lo_q, hi_q);
  endtask

  // drop valid and wait until every expected result is back
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (noise_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(int d, int f, int o, int p, int l);
    int vals [5];
    vals = '{d, f, o, p, l};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_AW'(i);
      cfg_wdata <= CFG_DW'(vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    dims_reg = 2'(d); smooth_reg = 1'(f); oct_reg = 4'(o);
    persist_reg = 16'(p); lacun_reg = 16'(l);
  endtask

  function automatic logic [CRD_W-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return {8'($urandom), 16'h0000};
      3:       return {8'($urandom), 16'hFFFF};
      default: return CRD_W'($urandom);
    endcase
  endfunction

  task automatic rand_range(output logic signed [RES_W-1:0] lo_q,
                            output logic signed [RES_W-1:0] hi_q);
    case ($urandom_range(0, 5))
      0: begin lo_q = 32'sh8000_0000; hi_q = 32'sh7FFF_FFFF; end
      1: begin lo_q = $urandom; hi_q = $urandom; end
      2: begin lo_q = 32'sd65536 + $urandom_range(0, 255); hi_q = -32'sd65536; end
      3: begin lo_q = $urandom; hi_q = lo_q; end
      default: begin
        lo_q = -32'sd65536 - $urandom_range(0, 4095);
        hi_q = 32'sd65536 + $urandom_range(0, 4095);
      end
    endcase
  endtask

  task automatic test_table_load();
    logic [7:0] shuffled [TABLE_SIZE];
    logic [7:0] tmp;
    int j;
    for (int i = 0; i < TABLE_SIZE; i++) shuffled[i] = 8'(i);
    for (int i = TABLE_SIZE - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = shuffled[i]; shuffled[i] = shuffled[j]; shuffled[j] = tmp;
    end
    for (int i = 0; i < TABLE_SIZE; i++)
      send_item(FUNC_LOAD, 8'(i), shuffled[i], CRD_W'($urandom), CRD_W'($urandom),
                CRD_W'($urandom), $urandom, $urandom);
  endtask

  // directed samples, first at the reset config (3D, smoothstep, one octave), then in 1D and 2D
  task automatic test_directed();
    sample('0, '0, '0, -32'sd65536, 32'sd65536);
    sample('1, '1, '1, -32'sd65536, 32'sd65536);
    sample(24'h00_8000, 24'h00_8000, 24'h00_8000, 32'sh8000_0000, 32'sh7FFF_FFFF);
    sample(24'hFF_FFFF, 24'h00_0000, 24'h7F_0001, 32'sh7FFF_FFFF, 32'sh8000_0000);
    sample(24'h12_3456, 24'h65_4321, 24'hAB_CDEF, 32'sd1000, 32'sd1000);
    sample(24'h80_0000, 24'h7F_FFFF, 24'h01_0000, 32'sd65536, -32'sd65536);
    sample(24'h00_0001, 24'hFE_FFFF, 24'hFF_0000, 32'sh8000_0000, 32'sh8000_0000);
    // loads at the table ends; contents stay defined
    send_item(FUNC_LOAD, 8'd0, 8'hFF, '1, '1, '1, '1, '1);
    send_item(FUNC_LOAD, 8'hFF, 8'd0, '0, '0, '0, '0, '0);
    sample(24'hFF_C000, 24'hFF_4000, 24'hFF_8000, -32'sd65536, 32'sd65536);
    sample(24'h00_4000, 24'h00_C000, 24'h00_2000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    drain();
    set_config(1, 0, 1, 32768, 8192);
    sample(24'h00_8000, '1, '1, -32'sd65536, 32'sd65536);
    sample(24'hFF_FFFF, '0, '0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    drain();
    set_config(2, 1, 2, 65535, 65535);
    sample(24'h7F_8000, 24'h80_8000, '1, -32'sd65536, 32'sd65536);
    sample(24'hFF_FFFF, 24'hFF_FFFF, '0, 32'sh7FFF_FFFF, 32'sh8000_0000);
    drain();
  endtask

  task automatic run_phase(int d, int f, int o, int p, int l, int count, bit no_idle);
    logic signed [RES_W-1:0] lo_q, hi_q;
    set_config(d, f, o, p, l);
    steady = no_idle;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(FUNC_LOAD, 8'($urandom), 8'($urandom), CRD_W'($urandom), CRD_W'($urandom),
                  CRD_W'($urandom), $urandom, $urandom);
      end else begin
        rand_range(lo_q, hi_q);
        sample(rand_coord(), rand_coord(), rand_coord(), lo_q, hi_q);
      end
    end
    drain();
    steady = 1'b0;
  endtask

  task automatic test_config_sweep();
    run_phase(1, 0, 1, 0, 0, 100, 0);
    run_phase(1, 1, 8, 65535, 65535, 100, 0);
    run_phase(2, 0, 4, 32768, 8192, 110, 1);
    run_phase(2, 1, 0, 40000, 4096, 100, 0);
    run_phase(3, 0, 3, 20000, 12000, 100, 0);
    run_phase(3, 1, 8, 65535, 8192, 110, 0);
    run_phase(0, 1, 15, 0, 65535, 100, 0);
    run_phase(3, 1, 9, 1, 1, 100, 0);
    run_phase(2, 1, 2, 50000, 20000, 100, 1);
    run_phase(3, 0, 8, 0, 0, 100, 0);
    run_phase(1, 1, 5, 65535, 4096, 100, 0);
    run_phase(3, 1, 1, 32768, 8192, 100, 0);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    n_errors = 0;
    steady = 1'b0;
    out_stall = 0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.func = FUNC_LOAD;
    in_bus.table_index = '0;
    in_bus.table_value = '0;
    in_bus.coord_x = '0;
    in_bus.coord_y = '0;
    in_bus.coord_z = '0;
    in_bus.out_min = '0;
    in_bus.out_max = '0;
    out_bus.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_load();
    test_directed();
    test_config_sweep();
    drain();
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### fractal_gradient_noise_unit.f
rtl/fgn_pkg.sv
rtl/fgn_if.sv
rtl/fgn_datapath.sv
rtl/fgn_ctrl.sv
rtl/fractal_gradient_noise_unit.sv
dv/tb.sv
